[src/kcsi_pkg.sv]
// ----------------------------------------------------------------------------
// kcsi_pkg
// Shared codes and types for the k-mer counting sort index builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kcsi_pkg;

    localparam logic [2:0] CMD_COUNT     = 3'd0;
    localparam logic [2:0] CMD_FINALIZE  = 3'd1;
    localparam logic [2:0] CMD_STORE     = 3'd2;
    localparam logic [2:0] CMD_FIXUP     = 3'd3;
    localparam logic [2:0] CMD_READ_TBL  = 3'd4;
    localparam logic [2:0] CMD_READ_LIST = 3'd5;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [1:0] STAT_PHASE    = 2'd2;

    localparam logic [1:0] PH_COUNT = 2'd0;
    localparam logic [1:0] PH_STORE = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    localparam logic REG_WORD_SIZE = 1'b0;
    localparam logic REG_CUTOFF    = 1'b1;

    // Datapath commands issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_REJECT,
        OP_FINISH,
        OP_ISSUE,
        OP_UPDATE,
        OP_READ_OUT,
        OP_WALK_INIT,
        OP_WALK_RD,
        OP_WALK_WR,
        OP_WALK_END
    } dp_op_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic clear_last;
        logic walk_last;
        logic legal;
        logic access;
        logic is_walk;
        logic is_read;
    } dp_stat_t;

endpackage

`default_nettype wire

[src/kcsi_ram.sv]
// ----------------------------------------------------------------------------
// kcsi_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/kcsi_ctrl.sv]
// ----------------------------------------------------------------------------
// kcsi_ctrl
// Sequencer: table clearing after reset, command dispatch, table walks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcsi_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire kcsi_pkg::dp_stat_t stat,
    output kcsi_pkg::dp_op_t        op
);
    import kcsi_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_UPDATE,
        S_READ_OUT,
        S_WALK_RD,
        S_WALK_WR,
        S_WALK_END
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                op = OP_CLEAR;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!stat.legal)
                begin
                    op         = OP_REJECT;
                    state_next = S_IDLE;
                end
                else if (stat.is_walk)
                begin
                    op         = OP_WALK_INIT;
                    state_next = S_WALK_RD;
                end
                else if (stat.access)
                begin
                    op         = OP_ISSUE;
                    state_next = stat.is_read ? S_READ_OUT : S_UPDATE;
                end
                else
                begin
                    op         = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            S_UPDATE:
            begin
                op         = OP_UPDATE;
                state_next = S_IDLE;
            end
            S_READ_OUT:
            begin
                op         = OP_READ_OUT;
                state_next = S_IDLE;
            end
            S_WALK_RD:
            begin
                op         = OP_WALK_RD;
                state_next = S_WALK_WR;
            end
            S_WALK_WR:
            begin
                op         = OP_WALK_WR;
                state_next = stat.walk_last ? S_WALK_END : S_WALK_RD;
            end
            S_WALK_END:
            begin
                op         = OP_WALK_END;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

[src/kcsi_dp.sv]
// ----------------------------------------------------------------------------
// kcsi_dp
// Datapath: configuration, command registers, first-level table and position
// list memories, running sum and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcsi_dp #(
    parameter int MAX_WORD_LEN = 10,
    parameter int LIST_DEPTH   = 4194304
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kcsi_pkg::dp_op_t   op,
    output kcsi_pkg::dp_stat_t      stat,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic [2:0]         command,
    input  wire logic [20:0]        word_index,
    input  wire logic [31:0]        position,
    input  wire logic [21:0]        read_index,
    output logic                    done,
    output logic [1:0]              status,
    output logic [31:0]             read_value,
    output logic [22:0]             pointer_total
);
    import kcsi_pkg::*;

    localparam int TBL_DEPTH = (1 << (2 * MAX_WORD_LEN)) + 1;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int LEN_W     = TBL_AW + 1;
    localparam int LIST_AW   = $clog2(LIST_DEPTH);
    localparam int SUM_W     = 32 + TBL_AW;
    localparam logic [3:0]        MAXK      = 4'(MAX_WORD_LEN);
    localparam logic [31:0]       LIST_LIM  = 32'(LIST_DEPTH);
    localparam logic [TBL_AW-1:0] CLR_LAST  = TBL_AW'(TBL_DEPTH - 1);

    logic [3:0]        word_size_reg;
    logic [31:0]       cutoff_reg;
    logic [2:0]        cmd_reg;
    logic [20:0]       ix_reg;
    logic [31:0]       pos_reg;
    logic [21:0]       ridx_reg;
    logic [31:0]       kept_reg, kept_next;
    logic [1:0]        phase_reg, phase_next;
    logic [TBL_AW-1:0] clr_reg, clr_next;
    logic [TBL_AW-1:0] walk_reg, walk_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [31:0]       last_reg, last_next;
    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic [31:0]       value_reg, value_next;

    logic [3:0]        kclamp;
    logic [LEN_W-1:0]  tbl_len;
    logic [TBL_AW-1:0] len_m1;
    logic              ix_ok, rt_ok, rl_ok;
    logic              tbl_we, list_we;
    logic [TBL_AW-1:0] tbl_addr;
    logic [31:0]       tbl_wdata, tbl_rdata;
    logic [LIST_AW-1:0] list_addr;
    logic [31:0]       list_rdata;
    logic [31:0]       entry_inc, entry_dec;
    logic [SUM_W-1:0]  sum_add;

    // Active table length: 4^k + 1 with k clamped
    always_comb
    begin
        kclamp = word_size_reg;
        if (word_size_reg == 4'd0)
        begin
            kclamp = 4'd1;
        end
        else if (word_size_reg > MAXK)
        begin
            kclamp = MAXK;
        end
    end

    assign tbl_len = (LEN_W'(1) << (5'(kclamp) << 1)) + LEN_W'(1);
    assign len_m1  = TBL_AW'(tbl_len - LEN_W'(1));
    assign ix_ok   = (32'(ix_reg) < 32'(tbl_len));
    assign rt_ok   = (32'(ridx_reg) < 32'(tbl_len));
    assign rl_ok   = (32'(ridx_reg) < LIST_LIM);

    assign entry_inc = tbl_rdata + 32'd1;
    assign entry_dec = tbl_rdata - 32'd1;
    assign sum_add   = sum_reg + SUM_W'(tbl_rdata);

    // Status towards the controller
    always_comb
    begin
        stat.clear_last = (clr_reg == CLR_LAST);
        stat.walk_last  = (cmd_reg == CMD_FINALIZE) ? (walk_reg == len_m1)
                                                    : (walk_reg == '0);
        stat.is_walk    = (cmd_reg == CMD_FINALIZE) || (cmd_reg == CMD_FIXUP);
        stat.is_read    = (cmd_reg == CMD_READ_TBL) || (cmd_reg == CMD_READ_LIST);
        case (cmd_reg)
            CMD_COUNT, CMD_FINALIZE: stat.legal = (phase_reg == PH_COUNT);
            CMD_STORE, CMD_FIXUP:    stat.legal = (phase_reg == PH_STORE);
            CMD_READ_TBL, CMD_READ_LIST: stat.legal = 1'b1;
            default:                 stat.legal = 1'b0;
        endcase
        case (cmd_reg)
            CMD_READ_TBL:  stat.access = rt_ok;
            CMD_READ_LIST: stat.access = rl_ok;
            default:       stat.access = ix_ok;
        endcase
    end

    always_comb
    begin
        kept_next   = kept_reg;
        phase_next  = phase_reg;
        clr_next    = clr_reg;
        walk_next   = walk_reg;
        sum_next    = sum_reg;
        last_next   = last_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        value_next  = value_reg;
        tbl_we      = 1'b0;
        tbl_addr    = TBL_AW'(ix_reg);
        tbl_wdata   = 32'd0;
        list_we     = 1'b0;
        list_addr   = LIST_AW'(ridx_reg);

        unique case (op)
            OP_CLEAR:
            begin
                tbl_we   = 1'b1;
                tbl_addr = clr_reg;
                clr_next = clr_reg + TBL_AW'(1);
            end
            OP_REJECT:
            begin
                done_next   = 1'b1;
                status_next = STAT_PHASE;
                value_next  = 32'd0;
            end
            OP_FINISH:
            begin
                done_next   = 1'b1;
                value_next  = 32'd0;
                status_next = (cmd_reg == CMD_COUNT && kept_reg > LIST_LIM)
                              ? STAT_OVERFLOW : STAT_OK;
            end
            OP_ISSUE:
            begin
                if (cmd_reg == CMD_READ_TBL)
                begin
                    tbl_addr = TBL_AW'(ridx_reg);
                end
            end
            OP_UPDATE:
            begin
                done_next   = 1'b1;
                value_next  = 32'd0;
                status_next = STAT_OK;
                if (cmd_reg == CMD_COUNT)
                begin
                    // saturated counters stay put
                    if (tbl_rdata != 32'hFFFF_FFFF)
                    begin
                        tbl_we    = 1'b1;
                        tbl_wdata = entry_inc;
                        if (entry_inc <= cutoff_reg)
                        begin
                            kept_next = kept_reg + 32'd1;
                            if (entry_inc == cutoff_reg)
                            begin
                                kept_next = kept_reg + 32'd1 - cutoff_reg;
                            end
                        end
                    end
                    if (kept_next > LIST_LIM)
                    begin
                        status_next = STAT_OVERFLOW;
                    end
                end
                else if (tbl_rdata != 32'd0)
                begin
                    tbl_we    = 1'b1;
                    tbl_wdata = entry_dec;
                    list_addr = LIST_AW'(entry_dec);
                    if (entry_dec < LIST_LIM)
                    begin
                        list_we = 1'b1;
                    end
                    else
                    begin
                        status_next = STAT_OVERFLOW;
                    end
                end
            end
            OP_READ_OUT:
            begin
                done_next   = 1'b1;
                status_next = STAT_OK;
                value_next  = (cmd_reg == CMD_READ_TBL) ? tbl_rdata : list_rdata;
            end
            OP_WALK_INIT:
            begin
                sum_next  = '0;
                last_next = kept_reg;
                walk_next = (cmd_reg == CMD_FINALIZE) ? '0 : len_m1;
            end
            OP_WALK_RD:
            begin
                tbl_addr = walk_reg;
            end
            OP_WALK_WR:
            begin
                tbl_addr = walk_reg;
                if (cmd_reg == CMD_FINALIZE)
                begin
                    tbl_we = 1'b1;
                    if (tbl_rdata < cutoff_reg)
                    begin
                        sum_next  = sum_add;
                        tbl_wdata = sum_add[31:0];
                    end
                    walk_next = walk_reg + TBL_AW'(1);
                end
                else
                begin
                    // fill empty entries with the next offset above
                    if (tbl_rdata == 32'd0)
                    begin
                        tbl_we    = 1'b1;
                        tbl_wdata = last_reg;
                    end
                    else
                    begin
                        last_next = tbl_rdata;
                    end
                    walk_next = walk_reg - TBL_AW'(1);
                end
            end
            OP_WALK_END:
            begin
                done_next   = 1'b1;
                value_next  = 32'd0;
                status_next = STAT_OK;
                if (cmd_reg == CMD_FINALIZE)
                begin
                    phase_next = PH_STORE;
                    kept_next  = (sum_reg > SUM_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                   : sum_reg[31:0];
                    if (sum_reg > SUM_W'(LIST_LIM))
                    begin
                        status_next = STAT_OVERFLOW;
                    end
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_size_reg <= 4'd10;
            cutoff_reg    <= 32'hFFFF_FFFF;
            kept_reg      <= 32'd0;
            phase_reg     <= PH_COUNT;
            clr_reg       <= '0;
            walk_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WORD_SIZE: word_size_reg <= cfg_data[3:0];
                    REG_CUTOFF:    cutoff_reg    <= cfg_data;
                    default:       ;
                endcase
            end
            kept_reg  <= kept_next;
            phase_reg <= phase_next;
            clr_reg   <= clr_next;
            walk_reg  <= walk_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_LOAD)
        begin
            cmd_reg  <= command;
            ix_reg   <= word_index;
            pos_reg  <= position;
            ridx_reg <= read_index;
        end
        sum_reg    <= sum_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    kcsi_ram #(
        .WIDTH (32),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    kcsi_ram #(
        .WIDTH (32),
        .DEPTH (LIST_DEPTH)
    ) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .addr  (list_addr),
        .wdata (pos_reg),
        .rdata (list_rdata)
    );

    assign done          = done_reg;
    assign status        = status_reg;
    assign read_value    = value_reg;
    assign pointer_total = (kept_reg > LIST_LIM) ? LIST_LIM[22:0] : kept_reg[22:0];

endmodule

`default_nettype wire

[src/kmer_counting_sort_index_top.sv]
// ----------------------------------------------------------------------------
// kmer_counting_sort_index_top
// Two-level k-mer index builder by counting sort.
//
//   channel   handshake        payload
//   command   start / busy     command, word_index, position, read_index
//   result    done (1 cycle)   status, read_value, pointer_total
//   config    cfg_we           cfg_index, cfg_data
//
// After reset all 4^MAX_WORD_LEN + 1 first-level table entries are cleared, one
// entry a cycle; busy stays high meanwhile.
// Count and store read the table entry and write it back; reads fetch the
// table or list entry; rejected or out-of-range commands finish at dispatch.
// Finalize and fixup walk each active table entry, read then write, over the
// single table port. A new transaction is taken in the cycle done is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmer_counting_sort_index_top #(
    parameter int MAX_WORD_LEN = 10,
    parameter int LIST_DEPTH   = 4194304
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  command,
    input  wire logic [20:0] word_index,
    input  wire logic [31:0] position,
    input  wire logic [21:0] read_index,
    output logic             done,
    output logic [1:0]       status,
    output logic [31:0]      read_value,
    output logic [22:0]      pointer_total,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    import kcsi_pkg::*;

    dp_op_t   op;
    dp_stat_t stat;

    kcsi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .op    (op)
    );

    kcsi_dp #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .LIST_DEPTH   (LIST_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .word_index    (word_index),
        .position      (position),
        .read_index    (read_index),
        .done          (done),
        .status        (status),
        .read_value    (read_value),
        .pointer_total (pointer_total)
    );

endmodule

`default_nettype wire
